// ===== rtl/rk4_pkg.sv =====
package rk4_pkg;

	// fixed field widths of the block's ports
	localparam int IO_WIDTH   = 48;
	localparam int STEP_WIDTH = 47;
	localparam int CFG_DATA_W = 64;
	localparam int ADDR_W     = 5;

	localparam int DEF_WORD_WIDTH = 48;
	localparam int DEF_FRAC_BITS  = 40;

	// multiplier consumes this many bits of its second operand per cycle
	localparam int MUL_CHUNK  = 16;
	// divide-by-six unit retires this many quotient bits per cycle
	localparam int DIV_DIGITS = 4;

	localparam logic [1:0] REG_STEP  = 2'd0;
	localparam logic [1:0] REG_DAMP  = 2'd1;
	localparam logic [1:0] REG_STIFF = 2'd2;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	localparam logic [STEP_WIDTH-1:0]      STEP_RST  = 47'd109951;
	localparam logic signed [IO_WIDTH-1:0] DAMP_RST  = 48'sd549755813888;
	localparam logic signed [IO_WIDTH-1:0] STIFF_RST = 48'sd137438953472;

	typedef struct packed {
		logic [STEP_WIDTH-1:0]      step;
		logic signed [IO_WIDTH-1:0] damp;
		logic signed [IO_WIDTH-1:0] stiff;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [1:0] {
		MUL_IDLE,
		MUL_RUN,
		MUL_SIGN,
		MUL_ROUND
	} mul_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_SIGN
	} div_state_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_MUL_K,
		SEQ_MUL_C1,
		SEQ_MUL_C2,
		SEQ_MUL_L,
		SEQ_MID,
		SEQ_DIV_U,
		SEQ_DIV_V,
		SEQ_OUT
	} seq_state_t;

endpackage

// ===== rtl/rk4_linear_second_order_ode_step_unit.sv =====
// Fourth-order Runge-Kutta stepper for u'' = -(c1*u' + c2*u) in signed fixed
// point (WORD_WIDTH-bit words, FRAC_BITS fraction bits, Q8.40 by default).
// A beat on the input channel with mode 0 loads position, value and slope
// from start_x/start_u/start_v; with mode 1 it advances them by one step of
// size h (step_size register) and the new triple comes back as one result
// beat, with overflow set if anything saturated on the way. After reset the
// state is x = 0, u = 0, v = 1.0. Registers sit on the APB port at byte
// addresses 0 (step_size), 8 (damping_ratio) and 16 (stiffness_ratio) and
// should be written only while the block is idle. A step beat runs sixteen
// products through one shared multicycle multiplier, which takes its second
// operand in NCH = ceil(max(WORD_WIDTH,48)/16) chunks of 16 bits, and two
// divide-by-six passes through a serial divider, which works through
// NDIG = ceil((WORD_WIDTH+3)/4) groups of 4 bits. in_ready is high only
// between items; a finished result waits in the output register, so the
// next item can be accepted before the previous result is taken.
module rk4_linear_second_order_ode_step_unit #(
	parameter int WORD_WIDTH = rk4_pkg::DEF_WORD_WIDTH,
	parameter int FRAC_BITS  = rk4_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rk4_pkg::ADDR_W-1:0]           paddr,
	input  logic [rk4_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [rk4_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready,
	// input beats
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 mode,
	input  logic signed [rk4_pkg::IO_WIDTH-1:0]  start_x,
	input  logic signed [rk4_pkg::IO_WIDTH-1:0]  start_u,
	input  logic signed [rk4_pkg::IO_WIDTH-1:0]  start_v,
	// result beats
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [rk4_pkg::IO_WIDTH-1:0]  pos_x,
	output logic signed [rk4_pkg::IO_WIDTH-1:0]  value_u,
	output logic signed [rk4_pkg::IO_WIDTH-1:0]  slope_v,
	output logic                                 overflow
);
	import rk4_pkg::*;

	localparam int W   = WORD_WIDTH;
	// operand width of the shared multiplier: h and the ratios are 47/48 bits
	localparam int OPW = (W > IO_WIDTH) ? W : IO_WIDTH;
	localparam int PW  = 2 * OPW + 1;
	// working width for every add before saturation
	localparam int XW  = PW + 2;
	// weighted sum k1 + 2k2 + 2k3 + k4 needs three extra bits
	localparam int SW  = W + 3;

	localparam logic signed [XW-1:0] MAX_X = XW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [XW-1:0] MIN_X = ~MAX_X;
	localparam logic signed [W-1:0]  ONE_W =
		(FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : MAX_X[W-1:0];

	// clamp to the word range; MSB of the result is the saturation flag
	function automatic logic [W:0] sat_w(input logic signed [XW-1:0] x);
		logic [W:0] res;
		if (x > MAX_X) begin
			res = {1'b1, MAX_X[W-1:0]};
		end else if (x < MIN_X) begin
			res = {1'b1, MIN_X[W-1:0]};
		end else begin
			res = {1'b0, x[W-1:0]};
		end
		return res;
	endfunction

	cfg_t       cfg;
	seq_state_t state_q, state_d;

	// architectural state
	logic signed [W-1:0]  pos_q, u_q, v_q;
	// stage work registers
	logic signed [W-1:0]  us_q, vs_q, k_q, l_q, f_q;
	logic signed [PW-1:0] nacc_q;      // holds -rnd(c1*vs) until c2*us is in
	logic signed [SW-1:0] sk_q, sl_q;  // running weighted stage sums
	logic [1:0]           stage_q;
	logic                 ovf_q;
	logic                 issued_q;

	// output register
	logic                        out_valid_q;
	logic signed [IO_WIDTH-1:0]  pos_x_q, value_u_q, slope_v_q;
	logic                        overflow_q;

	logic                  mul_start, div_start;
	logic signed [OPW-1:0] mul_a, mul_b;
	logic signed [PW-1:0]  mul_r;
	unit_stat_t            mul_stat, div_stat;
	logic signed [SW-1:0]  div_s, div_q;

	logic                  accept;
	logic                  wt2;
	logic signed [W-1:0]   k_step, l_step, div_base;
	logic signed [SW-1:0]  k_ext, l_ext;
	logic [W:0]            sat_r, sat_f, sat_us, sat_vs, sat_div, sat_pos;
	logic [W:0]            sat_sx, sat_su, sat_sv;

	rk4_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rk4_mul #(
		.OPW       (OPW),
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.r      (mul_r)
	);

	rk4_div6 #(
		.SW (SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.s      (div_s),
		.stat   (div_stat),
		.q      (div_q)
	);

	assign in_ready  = (state_q == SEQ_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign value_u   = value_u_q;
	assign slope_v   = slope_v_q;
	assign overflow  = overflow_q;

	// multiplier operand routing per sequencer state
	always_comb begin
		unique case (state_q)
			SEQ_MUL_C1: begin
				mul_a = OPW'(cfg.damp);
				mul_b = OPW'(vs_q);
			end
			SEQ_MUL_C2: begin
				mul_a = OPW'(cfg.stiff);
				mul_b = OPW'(us_q);
			end
			SEQ_MUL_L: begin
				mul_a = $signed(OPW'(cfg.step));
				mul_b = OPW'(f_q);
			end
			default: begin
				mul_a = $signed(OPW'(cfg.step));
				mul_b = OPW'(vs_q);
			end
		endcase
	end

	assign div_s    = (state_q == SEQ_DIV_V) ? sl_q : sk_q;
	assign div_base = (state_q == SEQ_DIV_V) ? v_q : u_q;

	// half increments for the two mid points, full one for the end point
	assign k_step = (stage_q == 2'd2) ? k_q : (k_q >>> 1);
	assign l_step = (stage_q == 2'd2) ? l_q : (l_q >>> 1);
	assign wt2    = (stage_q == 2'd1) || (stage_q == 2'd2);
	assign k_ext  = SW'(k_q);
	assign l_ext  = SW'(l_q);

	assign sat_r   = sat_w(XW'(mul_r));
	assign sat_f   = sat_w(XW'(nacc_q) - XW'(mul_r));
	assign sat_us  = sat_w(XW'(u_q) + XW'(k_step));
	assign sat_vs  = sat_w(XW'(v_q) + XW'(l_step));
	assign sat_div = sat_w(XW'(div_base) + XW'(div_q));
	assign sat_pos = sat_w(XW'(pos_q) + $signed(XW'(cfg.step)));
	assign sat_sx  = sat_w(XW'(start_x));
	assign sat_su  = sat_w(XW'(start_u));
	assign sat_sv  = sat_w(XW'(start_v));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					state_d = (mode == MODE_STEP) ? SEQ_MUL_K : SEQ_OUT;
				end
			end
			SEQ_MUL_K: begin
				mul_start = !issued_q;
				if (mul_stat.done) state_d = SEQ_MUL_C1;
			end
			SEQ_MUL_C1: begin
				mul_start = !issued_q;
				if (mul_stat.done) state_d = SEQ_MUL_C2;
			end
			SEQ_MUL_C2: begin
				mul_start = !issued_q;
				if (mul_stat.done) state_d = SEQ_MUL_L;
			end
			SEQ_MUL_L: begin
				mul_start = !issued_q;
				if (mul_stat.done) state_d = SEQ_MID;
			end
			SEQ_MID: state_d = (stage_q == 2'd3) ? SEQ_DIV_U : SEQ_MUL_K;
			SEQ_DIV_U: begin
				div_start = !issued_q;
				if (div_stat.done) state_d = SEQ_DIV_V;
			end
			SEQ_DIV_V: begin
				div_start = !issued_q;
				if (div_stat.done) state_d = SEQ_OUT;
			end
			SEQ_OUT: begin
				if (!out_valid_q || out_ready) state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			u_q         <= '0;
			v_q         <= ONE_W;
			stage_q     <= '0;
			ovf_q       <= 1'b0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_stat.done || div_stat.done) begin
				issued_q <= 1'b0;
			end else if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end

			if (state_q == SEQ_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				SEQ_IDLE: begin
					if (accept) begin
						stage_q <= '0;
						if (mode == MODE_STEP) begin
							ovf_q <= 1'b0;
						end else begin
							pos_q <= sat_sx[W-1:0];
							u_q   <= sat_su[W-1:0];
							v_q   <= sat_sv[W-1:0];
							ovf_q <= sat_sx[W] | sat_su[W] | sat_sv[W];
						end
					end
				end
				SEQ_MUL_K, SEQ_MUL_L: begin
					if (mul_stat.done) ovf_q <= ovf_q | sat_r[W];
				end
				SEQ_MUL_C2: begin
					if (mul_stat.done) ovf_q <= ovf_q | sat_f[W];
				end
				SEQ_MID: begin
					stage_q <= stage_q + 1'b1;
					// the end-point sums are never used, so their flags are not either
					if (stage_q != 2'd3) ovf_q <= ovf_q | sat_us[W] | sat_vs[W];
				end
				SEQ_DIV_U: begin
					if (div_stat.done) begin
						u_q   <= sat_div[W-1:0];
						ovf_q <= ovf_q | sat_div[W];
					end
				end
				SEQ_DIV_V: begin
					if (div_stat.done) begin
						v_q   <= sat_div[W-1:0];
						pos_q <= sat_pos[W-1:0];
						ovf_q <= ovf_q | sat_div[W] | sat_pos[W];
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					us_q <= u_q;
					vs_q <= v_q;
					sk_q <= '0;
					sl_q <= '0;
				end
			end
			SEQ_MUL_K:  if (mul_stat.done) k_q <= sat_r[W-1:0];
			SEQ_MUL_C1: if (mul_stat.done) nacc_q <= -mul_r;
			SEQ_MUL_C2: if (mul_stat.done) f_q <= sat_f[W-1:0];
			SEQ_MUL_L:  if (mul_stat.done) l_q <= sat_r[W-1:0];
			SEQ_MID: begin
				sk_q <= sk_q + (wt2 ? (k_ext <<< 1) : k_ext);
				sl_q <= sl_q + (wt2 ? (l_ext <<< 1) : l_ext);
				us_q <= sat_us[W-1:0];
				vs_q <= sat_vs[W-1:0];
			end
			SEQ_OUT: begin
				if (!out_valid_q || out_ready) begin
					pos_x_q    <= IO_WIDTH'(pos_q);
					value_u_q  <= IO_WIDTH'(u_q);
					slope_v_q  <= IO_WIDTH'(v_q);
					overflow_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/rk4_apb_regs.sv =====
module rk4_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rk4_pkg::ADDR_W-1:0]      paddr,
	input  logic [rk4_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [rk4_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	output rk4_pkg::cfg_t                   cfg
);
	import rk4_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step  <= STEP_RST;
			cfg_q.damp  <= DAMP_RST;
			cfg_q.stiff <= STIFF_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_STEP:  cfg_q.step  <= pwdata[STEP_WIDTH-1:0];
				REG_DAMP:  cfg_q.damp  <= pwdata[IO_WIDTH-1:0];
				REG_STIFF: cfg_q.stiff <= pwdata[IO_WIDTH-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STEP:  prdata = CFG_DATA_W'(cfg_q.step);
			REG_DAMP:  prdata = CFG_DATA_W'(cfg_q.damp);
			REG_STIFF: prdata = CFG_DATA_W'(cfg_q.stiff);
			default:   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/rk4_mul.sv =====
module rk4_mul #(
	parameter int OPW       = 48,
	parameter int FRAC_BITS = 40
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [OPW-1:0]     a,
	input  logic signed [OPW-1:0]     b,
	output rk4_pkg::unit_stat_t       stat,
	output logic signed [2*OPW:0]     r
);
	import rk4_pkg::*;

	localparam int PW  = 2 * OPW + 1;
	localparam int NCH = (OPW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BW  = NCH * MUL_CHUNK;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int AW  = BW + OPW;
	localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	mul_state_t state_q, state_d;

	logic [OPW-1:0]           ma_q;
	logic [BW-1:0]            mb_q;
	logic [AW-1:0]            acc_q;
	logic                     neg_q;
	logic [CW-1:0]            cnt_q;
	logic signed [PW-1:0]     p_q;
	logic signed [PW-1:0]     r_q;
	logic                     done_q;

	logic [OPW-1:0]           abs_a, abs_b;
	logic [OPW+MUL_CHUNK-1:0] part;
	logic [PW-1:0]            mag;
	logic signed [PW-1:0]     rsum;

	assign abs_a = a[OPW-1] ? (~a + 1'b1) : a;
	assign abs_b = b[OPW-1] ? (~b + 1'b1) : b;
	assign part  = ma_q * mb_q[BW-1 -: MUL_CHUNK];
	assign mag   = acc_q[PW-1:0];
	assign rsum  = p_q + RND;

	assign stat.busy = (state_q != MUL_IDLE);
	assign stat.done = done_q;
	assign r         = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MUL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MUL_IDLE:  if (start) state_d = MUL_RUN;
			MUL_RUN:   if (cnt_q == '0) state_d = MUL_SIGN;
			MUL_SIGN:  state_d = MUL_ROUND;
			MUL_ROUND: state_d = MUL_IDLE;
			default:   state_d = MUL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (state_q == MUL_ROUND);
			if (state_q == MUL_IDLE && start) begin
				cnt_q <= CW'(NCH - 1);
			end else if (state_q == MUL_RUN) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// magnitude product, MSB chunk of b first, then sign and rounding
	always_ff @(posedge clk) begin
		unique case (state_q)
			MUL_IDLE: begin
				if (start) begin
					ma_q  <= abs_a;
					mb_q  <= BW'(abs_b);
					acc_q <= '0;
					neg_q <= a[OPW-1] ^ b[OPW-1];
				end
			end
			MUL_RUN: begin
				acc_q <= (acc_q << MUL_CHUNK) + AW'(part);
				mb_q  <= mb_q << MUL_CHUNK;
			end
			MUL_SIGN:  p_q <= neg_q ? (~mag + 1'b1) : mag;
			MUL_ROUND: r_q <= rsum >>> FRAC_BITS;
			default:   ;
		endcase
	end

endmodule

// ===== rtl/rk4_div6.sv =====
module rk4_div6 #(
	parameter int SW = 51
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [SW-1:0]  s,
	output rk4_pkg::unit_stat_t   stat,
	output logic signed [SW-1:0]  q
);
	import rk4_pkg::*;

	localparam int NDIG = (SW + DIV_DIGITS - 1) / DIV_DIGITS;
	localparam int MW   = NDIG * DIV_DIGITS;
	localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

	div_state_t state_q, state_d;

	logic [MW-1:0]          m_q;
	logic [2:0]             rem_q;
	logic                   neg_q;
	logic [CW-1:0]          cnt_q;
	logic signed [SW-1:0]   q_q;
	logic                   done_q;

	logic [SW-1:0]          s_u, mag_in, quo;
	logic [3:0]             r;
	logic [DIV_DIGITS-1:0]  qd;

	// |s| + 3 so that the floor quotient rounds ties away from zero
	assign s_u    = s;
	assign mag_in = s[SW-1] ? (~s_u + SW'(4)) : (s_u + SW'(3));
	assign quo    = m_q[SW-1:0];

	always_comb begin
		r  = {1'b0, rem_q};
		qd = '0;
		for (int i = 0; i < DIV_DIGITS; i++) begin
			r = {r[2:0], m_q[MW-1-i]};
			if (r >= 4'd6) begin
				r = r - 4'd6;
				qd[DIV_DIGITS-1-i] = 1'b1;
			end
		end
	end

	assign stat.busy = (state_q != DIV_IDLE);
	assign stat.done = done_q;
	assign q         = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: if (start) state_d = DIV_RUN;
			DIV_RUN:  if (cnt_q == '0) state_d = DIV_SIGN;
			DIV_SIGN: state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (state_q == DIV_SIGN);
			if (state_q == DIV_IDLE && start) begin
				cnt_q <= CW'(NDIG - 1);
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				if (start) begin
					m_q   <= MW'(mag_in);
					rem_q <= '0;
					neg_q <= s[SW-1];
				end
			end
			DIV_RUN: begin
				m_q   <= {m_q[MW-DIV_DIGITS-1:0], qd};
				rem_q <= r[2:0];
			end
			DIV_SIGN: q_q <= neg_q ? (~quo + 1'b1) : quo;
			default:  ;
		endcase
	end

endmodule
